@@ rtl/raycast_column_texture_mapper_assert.svh @@
// Assertion macros used by the column texture mapper controller
`ifndef RAYCAST_COLUMN_TEXTURE_MAPPER_ASSERT_SVH
`define RAYCAST_COLUMN_TEXTURE_MAPPER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define RCTM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rctm assertion failed");

// Check that cons holds in the cycle after ante
`define RCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rctm assertion failed");

`endif

@@ rtl/rctm_pkg.sv @@
// Shared constants, codes and control structs of the column texture mapper
package rctm_pkg;

  localparam int SCREEN_HEIGHT = 512;
  localparam int LINE_MAX      = 65535;
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int LH_W          = $clog2(LINE_MAX + 1);
  localparam int HALF_W        = LH_W - 1;
  localparam int MID           = SCREEN_HEIGHT / 2;
  localparam logic [31:0] LH_DIVIDEND = 32'(SCREEN_HEIGHT) << 16;

  // Pixel kinds
  localparam logic [1:0] KIND_CEIL  = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_FLOOR = 2'd2;

  // Texture ids
  localparam logic [2:0] TID_EAST  = 3'd0;
  localparam logic [2:0] TID_WEST  = 3'd1;
  localparam logic [2:0] TID_SOUTH = 3'd2;
  localparam logic [2:0] TID_NORTH = 3'd3;
  localparam logic [2:0] TID_DOOR  = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_CEIL_COLOR  = 2'd0;
  localparam logic [1:0] REG_FLOOR_COLOR = 2'd1;
  localparam logic [1:0] REG_TEX_WIDTH   = 2'd2;
  localparam logic [1:0] REG_TEX_HEIGHT  = 2'd3;

  // Input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_ROW  = 1'b1;

  typedef struct packed {
    logic load;
    logic row;
    logic lh_latch;
    logic step_start;
    logic step_latch;
    logic pos_write;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/rctm_div.sv @@
// Iterative restoring divider, one quotient bit per cycle
module rctm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [23:0] dsr_r, dsr_nxt;
  logic [24:0] trial;
  logic        fits;

  // Load operands on start, else one shift-subtract step while busy
  always_comb begin
    trial    = {rem_r, quo_r[31]};
    fits     = trial >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? 24'(trial - {1'b0, dsr_r}) : trial[23:0];
      quo_nxt = {quo_r[30:0], fits};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/rctm_datapath.sv @@
// Ray setup arithmetic, row pixel generation, registers and output stage
module rctm_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rctm_pkg::cmd_t       cmd,
  output rctm_pkg::stat_t      stat,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic [9:0]           in_column,
  input  logic [23:0]          in_perp_dist,
  input  logic                 in_hit_side,
  input  logic                 in_is_door,
  input  logic signed [23:0]   in_dir_x,
  input  logic signed [23:0]   in_dir_y,
  input  logic [23:0]          in_player_x,
  input  logic [23:0]          in_player_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_pixel_kind,
  output logic [9:0]           out_column,
  output logic [8:0]           out_row,
  output logic [2:0]           out_texture_id,
  output logic [9:0]           out_texel_x,
  output logic [9:0]           out_texel_y,
  output logic [23:0]          out_flat_color,
  output logic                 out_last_row
);

  localparam int RW = rctm_pkg::ROW_W;
  localparam int LW = rctm_pkg::LH_W;
  localparam int HW = rctm_pkg::HALF_W;

  // Configuration registers
  logic [23:0] ceil_color_r, floor_color_r;
  logic [10:0] tex_w_r, tex_h_r, tw, th;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_color_r  <= '0;
      floor_color_r <= '0;
      tex_w_r       <= 11'd64;
      tex_h_r       <= 11'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rctm_pkg::REG_CEIL_COLOR:  ceil_color_r  <= cfg_data;
        rctm_pkg::REG_FLOOR_COLOR: floor_color_r <= cfg_data;
        rctm_pkg::REG_TEX_WIDTH:   tex_w_r       <= cfg_data[10:0];
        rctm_pkg::REG_TEX_HEIGHT:  tex_h_r       <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign tw = (tex_w_r == '0) ? 11'd1 : tex_w_r;
  assign th = (tex_h_r == '0) ? 11'd1 : tex_h_r;

  // Divider shared by line height and texture step
  logic        div_done;
  logic [31:0] div_q, div_dividend;
  logic [23:0] div_divisor;
  logic [LW-1:0] lh_r;

  assign div_dividend = cmd.step_start ? {5'd0, th, 16'd0} : rctm_pkg::LH_DIVIDEND;
  assign div_divisor  = cmd.step_start ?
                        ((lh_r == '0) ? 24'd1 : 24'(lh_r)) : in_perp_dist;

  rctm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load | cmd.step_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Capture ray data at load
  logic [9:0]  ray_col_r, pend_col_r;
  logic [2:0]  tex_sel_r, pend_sel_r;
  logic        mirror_r;
  logic signed [47:0] hprod_r;
  logic [23:0] hbase_r;
  logic        dx_pos, dy_pos, dy_neg;

  assign dx_pos = !in_dir_x[23] && (in_dir_x != '0);
  assign dy_pos = !in_dir_y[23] && (in_dir_y != '0);
  assign dy_neg = in_dir_y[23];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pend_col_r <= in_column;
      if (in_is_door)       pend_sel_r <= rctm_pkg::TID_DOOR;
      else if (!in_hit_side) pend_sel_r <= dx_pos ? rctm_pkg::TID_EAST : rctm_pkg::TID_WEST;
      else                  pend_sel_r <= dy_pos ? rctm_pkg::TID_SOUTH : rctm_pkg::TID_NORTH;
      mirror_r <= (!in_hit_side && dx_pos) || (in_hit_side && dy_neg);
      hprod_r  <= $signed({1'b0, in_perp_dist}) * (in_hit_side ? in_dir_x : in_dir_y);
      hbase_r  <= in_hit_side ? in_player_x : in_player_y;
    end
  end

  // Hit fraction and texture column pipeline, settles while the divider runs
  logic [31:0] frac_r;
  logic [42:0] txp_r;
  always_ff @(posedge clk) begin
    frac_r <= {hbase_r[15:0], 16'd0} + hprod_r[31:0];
    txp_r  <= frac_r * tw;
  end

  // Line height, slice bounds, texture column and texture step
  logic [HW-1:0] half;
  logic [RW-1:0] slice_start_r, slice_end_r;
  logic [HW-1:0] off_r;
  logic [9:0]    tex_col_r;
  logic [10:0]   tx_raw;
  logic [31:0]   step_r, pos_r;
  logic [HW:0]   half_mid;

  assign half     = lh_r[LW-1:1];
  assign half_mid = {1'b0, half} + (HW+1)'(rctm_pkg::MID);
  assign tx_raw   = txp_r[42:32];

  always_ff @(posedge clk) begin
    if (cmd.lh_latch)
      lh_r <= (div_q > 32'(rctm_pkg::LINE_MAX)) ? LW'(rctm_pkg::LINE_MAX) : div_q[LW-1:0];
    if (cmd.step_start) begin
      slice_start_r <= (half >= HW'(rctm_pkg::MID)) ? '0 :
                       RW'(HW'(rctm_pkg::MID) - half);
      slice_end_r   <= (half_mid >= (HW+1)'(rctm_pkg::SCREEN_HEIGHT)) ?
                       RW'(rctm_pkg::SCREEN_HEIGHT - 1) : half_mid[RW-1:0];
      off_r         <= (half >= HW'(rctm_pkg::MID)) ? HW'(half - HW'(rctm_pkg::MID)) : '0;
      tex_col_r     <= mirror_r ? 10'(tw - tx_raw - 11'd1) : tx_raw[9:0];
    end
    if (cmd.step_latch)
      step_r <= div_q;
  end

  // Row walk and ray state
  logic          loaded_r;
  logic [RW-1:0] row_r;
  logic [31:0]   pos_c;
  logic [1:0]    kind;
  logic [31:0]   tex_pos_nxt;
  logic [46:0]   pos_prod;
  logic          emit;

  assign pos_prod = off_r * step_r;
  assign pos_c    = (pos_r >= {5'd0, th, 16'd0}) ? '0 : pos_r;
  assign emit     = cmd.row && loaded_r;

  always_comb begin
    tex_pos_nxt = pos_r;
    if (row_r < slice_start_r)     kind = rctm_pkg::KIND_CEIL;
    else if (row_r <= slice_end_r) kind = rctm_pkg::KIND_WALL;
    else                           kind = rctm_pkg::KIND_FLOOR;
    if (kind == rctm_pkg::KIND_WALL)
      tex_pos_nxt = pos_c + step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= 1'b0;
      row_r     <= '0;
      ray_col_r <= '0;
      tex_sel_r <= '0;
      pos_r     <= '0;
    end else if (cmd.pos_write) begin
      loaded_r  <= 1'b1;
      row_r     <= '0;
      ray_col_r <= pend_col_r;
      tex_sel_r <= pend_sel_r;
      pos_r     <= pos_prod[31:0];
    end else if (emit) begin
      pos_r <= tex_pos_nxt;
      if (row_r == RW'(rctm_pkg::SCREEN_HEIGHT - 1)) loaded_r <= 1'b0;
      else                                          row_r <= row_r + 1'b1;
    end
  end

  // Output register
  logic        out_valid_r;
  logic [1:0]  o_kind_r;
  logic [9:0]  o_col_r, o_tx_r, o_ty_r;
  logic [8:0]  o_row_r;
  logic [2:0]  o_tid_r;
  logic [23:0] o_color_r;
  logic        o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
    if (emit) begin
      o_kind_r  <= kind;
      o_col_r   <= ray_col_r;
      o_row_r   <= 9'(row_r);
      o_last_r  <= row_r == RW'(rctm_pkg::SCREEN_HEIGHT - 1);
      o_tid_r   <= (kind == rctm_pkg::KIND_WALL) ? tex_sel_r : '0;
      o_tx_r    <= (kind == rctm_pkg::KIND_WALL) ? tex_col_r : '0;
      o_ty_r    <= (kind == rctm_pkg::KIND_WALL) ? pos_c[25:16] : '0;
      o_color_r <= (kind == rctm_pkg::KIND_CEIL) ? ceil_color_r :
                   (kind == rctm_pkg::KIND_FLOOR) ? floor_color_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_kind = o_kind_r;
  assign out_column     = o_col_r;
  assign out_row        = o_row_r;
  assign out_texture_id = o_tid_r;
  assign out_texel_x    = o_tx_r;
  assign out_texel_y    = o_ty_r;
  assign out_flat_color = o_color_r;
  assign out_last_row   = o_last_r;

  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

@@ rtl/rctm_ctrl.sv @@
// Controller state machine sequencing ray setup and row transactions
`include "raycast_column_texture_mapper_assert.svh"
module rctm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_func,
  input  rctm_pkg::stat_t stat,
  output rctm_pkg::cmd_t  cmd,
  output logic            in_stall
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DIV_LH   = 5'b00010,
    S_STEP_GO  = 5'b00100,
    S_DIV_STEP = 5'b01000,
    S_POS      = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_stall = !((state_r == S_IDLE) && stat.out_free);
  assign take     = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (in_func == rctm_pkg::FUNC_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = S_DIV_LH;
          end else begin
            cmd.row = 1'b1;
          end
        end
      end
      S_DIV_LH: begin
        if (stat.div_done) begin
          cmd.lh_latch = 1'b1;
          state_nxt    = S_STEP_GO;
        end
      end
      S_STEP_GO: begin
        cmd.step_start = 1'b1;
        state_nxt      = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        if (stat.div_done) begin
          cmd.step_latch = 1'b1;
          state_nxt      = S_POS;
        end
      end
      S_POS: begin
        cmd.pos_write = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `RCTM_ASSERT_SAME(a_stall_busy, clk, rst_n, state_r != S_IDLE, in_stall)
  `RCTM_ASSERT_SAME(a_done_wait, clk, rst_n, stat.div_done, (state_r == S_DIV_LH) || (state_r == S_DIV_STEP))
  `RCTM_ASSERT_NEXT(a_load_seq, clk, rst_n, take && (in_func == rctm_pkg::FUNC_LOAD), state_r == S_DIV_LH)

endmodule

@@ rtl/raycast_column_texture_mapper.sv @@
// Top level of the raycaster textured wall column mapper
// A load transaction (func 0) takes one ray's hit data and sets up the column; it
// occupies the block while the shared bit-serial divider runs twice, first for the
// line height, then for the texture step. Each row transaction (func 1) after that
// yields one pixel, top to bottom, at one per cycle while the output side keeps up.
// Rows after the bottom row, or before any load, give no result. Configuration
// writes are always ready.
module raycast_column_texture_mapper (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [9:0]         in_column,
  input  logic [23:0]        in_perp_dist,
  input  logic               in_hit_side,
  input  logic               in_is_door,
  input  logic signed [23:0] in_dir_x,
  input  logic signed [23:0] in_dir_y,
  input  logic [23:0]        in_player_x,
  input  logic [23:0]        in_player_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_pixel_kind,
  output logic [9:0]         out_column,
  output logic [8:0]         out_row,
  output logic [2:0]         out_texture_id,
  output logic [9:0]         out_texel_x,
  output logic [9:0]         out_texel_y,
  output logic [23:0]        out_flat_color,
  output logic               out_last_row
);

  rctm_pkg::cmd_t  cmd;
  rctm_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  rctm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  rctm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_column      (in_column),
    .in_perp_dist   (in_perp_dist),
    .in_hit_side    (in_hit_side),
    .in_is_door     (in_is_door),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_player_x    (in_player_x),
    .in_player_y    (in_player_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_kind (out_pixel_kind),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_texture_id (out_texture_id),
    .out_texel_x    (out_texel_x),
    .out_texel_y    (out_texel_y),
    .out_flat_color (out_flat_color),
    .out_last_row   (out_last_row)
  );

endmodule

@@ sim/raycast_column_texture_mapper_checker.sv @@
// Checker for the column texture mapper: watches the channels, predicts pixels, compares
`timescale 1ns / 1ps
module raycast_column_texture_mapper_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_func,
  input  logic [9:0]         in_column,
  input  logic [23:0]        in_perp_dist,
  input  logic               in_hit_side,
  input  logic               in_is_door,
  input  logic signed [23:0] in_dir_x,
  input  logic signed [23:0] in_dir_y,
  input  logic [23:0]        in_player_x,
  input  logic [23:0]        in_player_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_pixel_kind,
  input  logic [9:0]         out_column,
  input  logic [8:0]         out_row,
  input  logic [2:0]         out_texture_id,
  input  logic [9:0]         out_texel_x,
  input  logic [9:0]         out_texel_y,
  input  logic [23:0]        out_flat_color,
  input  logic               out_last_row,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  column;
    logic [8:0]  row;
    logic [2:0]  tex_id;
    logic [9:0]  tx;
    logic [9:0]  ty;
    logic [23:0] color;
    logic        last;
  } pixel_t;

  pixel_t pixel_q[$];

  // Register copies
  logic [23:0] ceil_color, floor_color;
  logic [10:0] tex_w, tex_h;

  // Column state
  logic [9:0]  ray_col;
  int unsigned slice_top, slice_bottom, row_cnt;
  logic [2:0]  tex_sel;
  logic [31:0] tex_col, tex_step, tex_pos;
  logic        ray_valid;

  assign pending = pixel_q.size();

  function automatic longint unsigned at_least_one(input logic [10:0] v);
    return (v == 0) ? 1 : longint'(v);
  endfunction

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report(what, got, want);
  endtask

  // Set up a column from one ray's hit data
  task automatic load_column();
    longint unsigned lh, half, off, frac, tx, tw, th, perp;
    longint hit, dx, dy;
    tw = at_least_one(tex_w);
    th = at_least_one(tex_h);
    perp = longint'(in_perp_dist);
    dx = longint'(in_dir_x);
    dy = longint'(in_dir_y);
    if (perp == 0) lh = rctm_pkg::LINE_MAX;
    else begin
      lh = (longint'(rctm_pkg::SCREEN_HEIGHT) << 16) / perp;
      if (lh > rctm_pkg::LINE_MAX) lh = rctm_pkg::LINE_MAX;
    end
    half = lh >> 1;
    slice_top = (half >= rctm_pkg::MID) ? 0 : rctm_pkg::MID - half;
    slice_bottom = (half + rctm_pkg::MID >= rctm_pkg::SCREEN_HEIGHT) ?
                   rctm_pkg::SCREEN_HEIGHT - 1 : half + rctm_pkg::MID;
    if (in_is_door) tex_sel = rctm_pkg::TID_DOOR;
    else if (!in_hit_side) tex_sel = (dx > 0) ? rctm_pkg::TID_EAST : rctm_pkg::TID_WEST;
    else tex_sel = (dy > 0) ? rctm_pkg::TID_SOUTH : rctm_pkg::TID_NORTH;
    if (!in_hit_side) hit = (longint'(in_player_y) << 16) + longint'(perp) * dy;
    else hit = (longint'(in_player_x) << 16) + longint'(perp) * dx;
    frac = 64'(hit) & 64'hFFFF_FFFF;
    tx = (frac * tw) >> 32;
    if ((!in_hit_side && dx > 0) || (in_hit_side && dy < 0)) tx = tw - tx - 1;
    tex_col = 32'(tx);
    tex_step = 32'((th << 16) / ((lh == 0) ? 1 : lh));
    off = (half >= rctm_pkg::MID) ? half - rctm_pkg::MID : 0;
    tex_pos = 32'(off * tex_step);
    ray_col = in_column;
    row_cnt = 0;
    ray_valid = 1'b1;
  endtask

  // Work out the next pixel of the column
  task automatic next_pixel();
    pixel_t p;
    longint unsigned th;
    p = '0;
    p.column = ray_col;
    p.row = 9'(row_cnt);
    p.last = (row_cnt == rctm_pkg::SCREEN_HEIGHT - 1);
    if (row_cnt < slice_top) begin
      p.kind = rctm_pkg::KIND_CEIL;
      p.color = ceil_color;
    end else if (row_cnt <= slice_bottom) begin
      th = at_least_one(tex_h);
      p.kind = rctm_pkg::KIND_WALL;
      p.tex_id = tex_sel;
      p.tx = 10'(tex_col);
      if (longint'(tex_pos) >= (th << 16)) tex_pos = 0;
      p.ty = 10'((longint'(tex_pos) >> 16) % th);
      tex_pos = tex_pos + tex_step;
    end else begin
      p.kind = rctm_pkg::KIND_FLOOR;
      p.color = floor_color;
    end
    pixel_q.push_back(p);
    if (row_cnt >= rctm_pkg::SCREEN_HEIGHT - 1) ray_valid = 1'b0;
    else row_cnt++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      ceil_color <= '0;
      floor_color <= '0;
      tex_w <= 11'd64;
      tex_h <= 11'd64;
      ray_valid = 1'b0;
      row_cnt = 0;
      tex_pos = '0;
      pixel_q.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rctm_pkg::REG_CEIL_COLOR:  ceil_color <= cfg_data;
          rctm_pkg::REG_FLOOR_COLOR: floor_color <= cfg_data;
          rctm_pkg::REG_TEX_WIDTH:   tex_w <= 11'(cfg_data);
          rctm_pkg::REG_TEX_HEIGHT:  tex_h <= 11'(cfg_data);
          default: ;
        endcase
      end
      // Predict on each accepted input transaction
      if (in_valid && !in_stall) begin
        if (in_func == rctm_pkg::FUNC_LOAD) load_column();
        else if (ray_valid) next_pixel();
      end
      // Compare each accepted result transaction
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) report("unexpected pixel row", out_row, 0);
        else begin
          want = pixel_q.pop_front();
          check_field("pixel_kind", out_pixel_kind, want.kind);
          check_field("column", out_column, want.column);
          check_field("row", out_row, want.row);
          check_field("texture_id", out_texture_id, want.tex_id);
          check_field("texel_x", out_texel_x, want.tx);
          check_field("texel_y", out_texel_y, want.ty);
          check_field("flat_color", out_flat_color, want.color);
          check_field("last_row", out_last_row, want.last);
        end
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
// Testbench top for the column texture mapper: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic        func;
    logic [9:0]  column;
    logic [23:0] perp;
    logic        side;
    logic        door;
    logic [23:0] dx;
    logic [23:0] dy;
    logic [23:0] px;
    logic [23:0] py;
  } ray_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [9:0] in_column = '0;
  logic [23:0] in_perp_dist = 24'd1;
  logic in_hit_side = 1'b0;
  logic in_is_door = 1'b0;
  logic signed [23:0] in_dir_x = '0;
  logic signed [23:0] in_dir_y = '0;
  logic [23:0] in_player_x = '0;
  logic [23:0] in_player_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_pixel_kind;
  logic [9:0] out_column;
  logic [8:0] out_row;
  logic [2:0] out_texture_id;
  logic [9:0] out_texel_x;
  logic [9:0] out_texel_y;
  logic [23:0] out_flat_color;
  logic out_last_row;

  int errors, pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  always #1 clk = ~clk;

  raycast_column_texture_mapper dut (.*);
  raycast_column_texture_mapper_checker checker_i (.*);

  // Receiver stall pattern
  always @(negedge clk) out_stall = ($urandom_range(0, 99) < stall_pct);

  // Send one input transaction, with random sender gaps first
  task automatic send(input ray_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_func = it.func;
    in_column = it.column;
    in_perp_dist = it.perp;
    in_hit_side = it.side;
    in_is_door = it.door;
    in_dir_x = it.dx;
    in_dir_y = it.dy;
    in_player_x = it.px;
    in_player_y = it.py;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    sent++;
  endtask

  function automatic ray_item_t random_item(input logic func);
    ray_item_t it;
    it.func = func;
    it.column = 10'($urandom);
    case ($urandom_range(0, 2))
      0: it.perp = 24'($urandom_range(1, 'h10000));
      1: it.perp = 24'($urandom_range('h10000, 'h100000));
      default: it.perp = 24'($urandom_range(1, 'hFFFFFF));
    endcase
    it.side = 1'($urandom);
    it.door = ($urandom_range(0, 4) == 0);
    it.dx = ($urandom_range(0, 9) == 0) ? '0 : 24'($urandom);
    it.dy = ($urandom_range(0, 9) == 0) ? '0 : 24'($urandom);
    it.px = 24'($urandom);
    it.py = 24'($urandom);
    return it;
  endfunction

  function automatic ray_item_t load_item(input logic [23:0] perp, input logic side,
                                          input logic door, input logic [23:0] dx,
                                          input logic [23:0] dy, input logic [23:0] pos);
    ray_item_t it;
    it = random_item(rctm_pkg::FUNC_LOAD);
    it.perp = perp;
    it.side = side;
    it.door = door;
    it.dx = dx;
    it.dy = dy;
    it.px = pos;
    it.py = pos;
    return it;
  endfunction

  task automatic send_rows(input int n);
    repeat (n) send(random_item(rctm_pkg::FUNC_ROW));
  endtask

  // Write all registers once the block has drained
  task automatic configure(input logic [23:0] ceil_c, input logic [23:0] floor_c,
                           input logic [10:0] tw, input logic [10:0] th);
    logic [23:0] vals[4];
    vals = '{ceil_c, floor_c, 24'(tw), 24'(th)};
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    foreach (vals[i]) begin
      cfg_index = 2'(i);
      cfg_data = vals[i];
      cfg_valid = 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
      cfg_valid = 1'b0;
    end
  endtask

  // Random phase: mostly whole load-and-rows sequences, some noise
  task automatic random_phase(input int quota);
    int stop_at;
    int n;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) send(random_item(1'($urandom)));
      end else begin
        send(random_item(rctm_pkg::FUNC_LOAD));
        if ($urandom_range(0, 9) == 0)
          n = rctm_pkg::SCREEN_HEIGHT + int'($urandom_range(0, 4));
        else n = int'($urandom_range(1, 300));
        // Hold the phase near its quota
        if (n > stop_at - sent) n = stop_at - sent;
        send_rows(n);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset registers, rows before any load, every face and the extremes
    send(random_item(rctm_pkg::FUNC_ROW));
    send(load_item(24'd1, 1'b0, 1'b1, 24'h7FFFFF, 24'h800000, 24'hFFFFFF));
    send_rows(3);
    send(load_item(24'hFFFFFF, 1'b0, 1'b0, 24'h000001, 24'h7FFFFF, 24'h000000));
    send_rows(3);
    send(load_item(24'h010000, 1'b1, 1'b0, 24'h800000, 24'h800000, 24'h123456));
    send_rows(2);
    send(load_item(24'h00C000, 1'b1, 1'b0, 24'h7FFFFF, 24'h000001, 24'hABCDEF));
    send(load_item(24'h020000, 1'b0, 1'b0, 24'h800000, 24'h654321, 24'h0FFFFF));
    send_rows(3);
    configure(24'hFFFFFF, 24'h000000, 11'd1, 11'd1024);
    send(load_item(24'h008000, 1'b1, 1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF));
    send_rows(3);

    // Random phases under each idling pattern and register setting
    configure(24'h000000, 24'hFFFFFF, 11'd1024, 11'd1);
    random_phase(400);
    idle_pct = 84;
    configure(24'($urandom), 24'($urandom), 11'($urandom_range(1, 1024)),
              11'($urandom_range(1, 1024)));
    random_phase(400);
    idle_pct = 0;
    stall_pct = 84;
    configure(24'hFFFFFF, 24'hFFFFFF, 11'd1024, 11'd1024);
    random_phase(400);
    idle_pct = 16;
    stall_pct = 16;
    configure(24'($urandom), 24'($urandom), 11'($urandom_range(1, 16)),
              11'($urandom_range(1, 16)));
    random_phase(400);

    // Drain and give the verdict
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
